/* rtl/core/ecal_pkg.sv */
// ----------------------------------------------------------------------------
// ecal_pkg: shared types and constants for the epoch to calendar unit
// Reciprocals for the constant divides, stage payload types, month table.
// ----------------------------------------------------------------------------
package ecal_pkg;

  // Reciprocals m = ceil(2^s / d), exact floor for every n below 2^N,
  // with s = N + ceil(log2 d).
  localparam logic [20:0] RecipDay20 = 21'(((64'd1 << 30) + 64'd674) / 64'd675);
  localparam logic [30:0] RecipDay30 = 31'(((64'd1 << 40) + 64'd674) / 64'd675);
  localparam logic [17:0] RecipHour  = 18'(((64'd1 << 29) + 64'd3599) / 64'd3600);
  localparam logic [12:0] RecipMin   = 13'(((64'd1 << 18) + 64'd59) / 64'd60);
  localparam logic [31:0] RecipEra   = 32'(((64'd1 << 49) + 64'd146096) / 64'd146097);
  localparam logic [18:0] Recip1460  = 19'(((64'd1 << 29) + 64'd1459) / 64'd1460);
  localparam logic [18:0] Recip365   = 19'(((64'd1 << 27) + 64'd364) / 64'd365);
  localparam logic [11:0] Recip153   = 12'(((64'd1 << 19) + 64'd152) / 64'd153);

  // Seconds per day = 128 * DayDivOdd
  localparam logic [9:0]  DayDivOdd   = 10'd675;
  localparam logic [9:0]  DayDivLast  = 10'd674;
  localparam logic [31:0] DaysShift   = 32'd719468;
  localparam logic [30:0] DaysPerEra  = 31'd146097;
  localparam logic [17:0] LastDayEra  = 18'd146096;

  typedef struct packed {
    logic signed [31:0] days;
    logic        [16:0] sod;
  } split_t;

  typedef struct packed {
    logic [4:0] hour;
    logic [5:0] minute;
    logic [5:0] second;
  } tod_t;

  typedef struct packed {
    logic signed [23:0] year;
    logic        [3:0]  month;
    logic        [4:0]  day;
  } date_t;

  // (153 * mp + 2) / 5: first day of each March-based month
  function automatic logic [8:0] month_start(input logic [3:0] mp);
    logic [8:0] r;
    case (mp)
      4'd0:    r = 9'd0;
      4'd1:    r = 9'd31;
      4'd2:    r = 9'd61;
      4'd3:    r = 9'd92;
      4'd4:    r = 9'd122;
      4'd5:    r = 9'd153;
      4'd6:    r = 9'd184;
      4'd7:    r = 9'd214;
      4'd8:    r = 9'd245;
      4'd9:    r = 9'd275;
      4'd10:   r = 9'd306;
      4'd11:   r = 9'd337;
      default: r = 9'd0;
    endcase
    return r;
  endfunction

endpackage

/* rtl/core/ecal_day_split.sv */
// ----------------------------------------------------------------------------
// ecal_day_split: floored split of seconds into days and second of day
// Stages 0 to 3; divide by 128 as a shift, then by 675 in two halves.
// ----------------------------------------------------------------------------
module ecal_day_split (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic [47:0]          secs_i,
  output ecal_pkg::split_t     split_o
);
  import ecal_pkg::*;

  // stage 0: fold sign, high half quotient
  logic [40:0] q1;
  logic        neg;
  logic [39:0] mag;
  logic [40:0] prod0;

  assign q1    = secs_i[47:7];
  assign neg   = secs_i[47];
  assign mag   = neg ? ~q1[39:0] : q1[39:0];
  assign prod0 = {21'b0, mag[39:20]} * {20'b0, RecipDay20};

  logic        s0_neg_q, s1_neg_q, s2_neg_q;
  logic [6:0]  s0_low_q, s1_low_q, s2_low_q;
  logic [19:0] s0_ah_q,  s0_al_q;
  logic [10:0] s0_qh_q,  s1_qh_q,  s2_qh_q;
  logic [29:0] s1_x_q,   s2_x_q;
  logic [19:0] s2_q2_q;
  split_t      split_q;

  // stage 1: high half remainder
  logic [19:0] qh675;
  logic [19:0] rh_full;
  assign qh675   = 20'(s0_qh_q) * 20'(DayDivOdd);
  assign rh_full = s0_ah_q - qh675;

  // stage 2: low half quotient
  logic [60:0] prod2;
  assign prod2 = {31'b0, s1_x_q} * {30'b0, RecipDay30};

  // stage 3: remainder, sign restore
  logic [29:0] q2x675;
  logic [29:0] r2_full;
  logic [30:0] quot;
  logic [9:0]  r1;
  logic signed [31:0] days_d;
  assign q2x675  = 30'(s2_q2_q) * 30'(DayDivOdd);
  assign r2_full = s2_x_q - q2x675;
  assign quot    = {s2_qh_q, s2_q2_q};
  assign days_d  = s2_neg_q ? ~$signed({1'b0, quot}) : $signed({1'b0, quot});
  assign r1      = s2_neg_q ? DayDivLast - r2_full[9:0] : r2_full[9:0];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      s0_neg_q <= neg;
      s0_low_q <= secs_i[6:0];
      s0_ah_q  <= mag[39:20];
      s0_al_q  <= mag[19:0];
      s0_qh_q  <= prod0[40:30];

      s1_neg_q <= s0_neg_q;
      s1_low_q <= s0_low_q;
      s1_qh_q  <= s0_qh_q;
      s1_x_q   <= {rh_full[9:0], s0_al_q};

      s2_neg_q <= s1_neg_q;
      s2_low_q <= s1_low_q;
      s2_qh_q  <= s1_qh_q;
      s2_x_q   <= s1_x_q;
      s2_q2_q  <= prod2[59:40];

      split_q.days <= days_d;
      split_q.sod  <= {r1, s2_low_q};
    end
  end

  assign split_o = split_q;

endmodule

/* rtl/core/ecal_tod.sv */
// ----------------------------------------------------------------------------
// ecal_tod: second of day to hour, minute, second
// Stages 4 to 12; four working stages, then a delay line to align.
// ----------------------------------------------------------------------------
module ecal_tod (
  input  logic              clk_i,
  input  logic              en_i,
  input  logic [16:0]       sod_i,
  output ecal_pkg::tod_t    tod_o
);
  import ecal_pkg::*;

  logic [16:0] t4_sod_q;
  logic [4:0]  t4_hour_q, t5_hour_q, t6_hour_q;
  logic [11:0] t5_rem_q,  t6_rem_q;
  logic [5:0]  t6_min_q;
  tod_t        dly_q [6];

  logic [34:0] prod_h;
  logic [16:0] h3600;
  logic [16:0] rem_full;
  logic [24:0] prod_m;
  logic [11:0] m60;
  logic [11:0] sec_full;

  assign prod_h   = {18'b0, sod_i} * {17'b0, RecipHour};
  assign h3600    = 17'(t4_hour_q) * 17'd3600;
  assign rem_full = t4_sod_q - h3600;
  assign prod_m   = {13'b0, t5_rem_q} * {12'b0, RecipMin};
  assign m60      = 12'(t6_min_q) * 12'd60;
  assign sec_full = t6_rem_q - m60;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      t4_sod_q  <= sod_i;
      t4_hour_q <= prod_h[33:29];

      t5_hour_q <= t4_hour_q;
      t5_rem_q  <= rem_full[11:0];

      t6_hour_q <= t5_hour_q;
      t6_rem_q  <= t5_rem_q;
      t6_min_q  <= prod_m[23:18];

      dly_q[0].hour   <= t6_hour_q;
      dly_q[0].minute <= t6_min_q;
      dly_q[0].second <= sec_full[5:0];
      for (int i = 1; i < 6; i++) begin
        dly_q[i] <= dly_q[i-1];
      end
    end
  end

  assign tod_o = dly_q[5];

endmodule

/* rtl/core/ecal_civil.sv */
// ----------------------------------------------------------------------------
// ecal_civil: day count to proleptic Gregorian year, month, day
// Stages 4 to 12; era split, year of era, day of year, month.
// ----------------------------------------------------------------------------
module ecal_civil (
  input  logic                 clk_i,
  input  logic                 en_i,
  input  logic signed [31:0]   days_i,
  output ecal_pkg::date_t      date_o
);
  import ecal_pkg::*;

  // stage 4: shift epoch to 0000-03-01, fold sign
  logic [31:0] z;
  logic        negz;
  logic [30:0] az;
  assign z    = days_i + DaysShift;
  assign negz = z[31];
  assign az   = negz ? ~z[30:0] : z[30:0];

  logic [30:0] c4_az_q, c5_az_q;
  logic        c4_neg_q, c5_neg_q;
  logic [13:0] c5_eq_q;

  // stage 5: era quotient
  logic [62:0] prod_era;
  assign prod_era = {32'b0, c4_az_q} * {31'b0, RecipEra};

  // stage 6: day of era
  logic [30:0] eqm;
  logic [30:0] dr_full;
  logic [17:0] dr;
  assign eqm     = 31'(c5_eq_q) * DaysPerEra;
  assign dr_full = c5_az_q - eqm;
  assign dr      = dr_full[17:0];

  logic [14:0] c6_era_q, c7_era_q, c8_era_q, c9_era_q, c10_era_q, c11_era_q;
  logic [17:0] c6_doe_q, c7_doe_q, c8_doe_q, c9_doe_q;

  // stage 7: leap corrections
  logic [36:0] prod_1460;
  logic [2:0]  cent;
  assign prod_1460 = {19'b0, c6_doe_q} * {18'b0, Recip1460};
  assign cent = {2'b0, c6_doe_q >= 18'd36524}  + {2'b0, c6_doe_q >= 18'd73048}
              + {2'b0, c6_doe_q >= 18'd109572} + {2'b0, c6_doe_q >= LastDayEra};

  logic [6:0]  c7_d1460_q;
  logic [2:0]  c7_cent_q;
  logic        c7_last_q;

  // stage 8: corrected day count
  logic [17:0] n_d;
  assign n_d = c7_doe_q - 18'(c7_d1460_q) + 18'(c7_cent_q) - 18'(c7_last_q);

  logic [17:0] c8_n_q;

  // stage 9: year of era
  logic [36:0] prod_365;
  assign prod_365 = {19'b0, c8_n_q} * {18'b0, Recip365};

  logic [8:0]  c9_yoe_q, c10_yoe_q, c11_yoe_q;

  // stage 10: day of year
  logic [17:0] y365;
  logic [1:0]  c100;
  logic [17:0] doy_full;
  assign y365 = 18'(c9_yoe_q) * 18'd365;
  assign c100 = {1'b0, c9_yoe_q >= 9'd100} + {1'b0, c9_yoe_q >= 9'd200}
              + {1'b0, c9_yoe_q >= 9'd300};
  assign doy_full = c9_doe_q - y365 - 18'(c9_yoe_q[8:2]) + 18'(c100);

  logic [8:0]  c10_doy_q, c11_doy_q;

  // stage 11: March-based month
  logic [10:0] mx;
  logic [22:0] prod_153;
  assign mx       = 11'(c10_doy_q) * 11'd5 + 11'd2;
  assign prod_153 = {12'b0, mx} * {11'b0, Recip153};

  logic [3:0]  c11_mp_q;

  // stage 12: calendar month, day, year
  logic [8:0]  day_full;
  logic [3:0]  month_d;
  logic [23:0] era400;
  logic [23:0] year_d;
  assign day_full = c11_doy_q - month_start(c11_mp_q) + 9'd1;
  assign month_d  = (c11_mp_q < 4'd10) ? c11_mp_q + 4'd3 : c11_mp_q - 4'd9;
  assign era400   = {{9{c11_era_q[14]}}, c11_era_q} * 24'd400;
  assign year_d   = era400 + 24'(c11_yoe_q) + 24'(month_d <= 4'd2);

  date_t date_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      c4_az_q    <= az;
      c4_neg_q   <= negz;

      c5_az_q    <= c4_az_q;
      c5_neg_q   <= c4_neg_q;
      c5_eq_q    <= prod_era[62:49];

      c6_era_q   <= c5_neg_q ? ~{1'b0, c5_eq_q} : {1'b0, c5_eq_q};
      c6_doe_q   <= c5_neg_q ? LastDayEra - dr : dr;

      c7_era_q   <= c6_era_q;
      c7_doe_q   <= c6_doe_q;
      c7_d1460_q <= prod_1460[35:29];
      c7_cent_q  <= cent;
      c7_last_q  <= (c6_doe_q >= LastDayEra);

      c8_era_q   <= c7_era_q;
      c8_doe_q   <= c7_doe_q;
      c8_n_q     <= n_d;

      c9_era_q   <= c8_era_q;
      c9_doe_q   <= c8_doe_q;
      c9_yoe_q   <= prod_365[35:27];

      c10_era_q  <= c9_era_q;
      c10_yoe_q  <= c9_yoe_q;
      c10_doy_q  <= doy_full[8:0];

      c11_era_q  <= c10_era_q;
      c11_yoe_q  <= c10_yoe_q;
      c11_doy_q  <= c10_doy_q;
      c11_mp_q   <= prod_153[22:19];

      date_q.year  <= $signed(year_d);
      date_q.month <= month_d;
      date_q.day   <= day_full[4:0];
    end
  end

  assign date_o = date_q;

endmodule

/* rtl/core/epoch_seconds_to_calendar_unit.sv */
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit: epoch seconds to Gregorian date and time
// Pipeline: 13 stages set by the constant-reciprocal multipliers, the first
//   loaded at the input transfer, plus the output stage.
// Throughput: one transfer per cycle in and out while the sink keeps up.
// Reset: clears the stage valid flags and the output/skid flags only;
//   the datapath registers are not reset.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit (
  input  logic        clk_i,
  input  logic        rst_ni,
  // slave side, tdata: epoch_seconds[47:0]
  input  logic        s_tvalid_i,
  output logic        s_tready_o,
  input  logic [47:0] s_tdata_i,
  // master side, tdata: year[23:0], month[27:24], day_of_month[32:28],
  //   hour[37:33], minute[43:38], second[49:44], zero pad[55:50]
  output logic        m_tvalid_o,
  input  logic        m_tready_i,
  output logic [55:0] m_tdata_o
);
  import ecal_pkg::*;

  localparam int unsigned NumStages = 13;

  // output register plus one skid slot
  logic        out_vld_q, out_vld_d;
  logic        skid_vld_q, skid_vld_d;
  logic [55:0] out_data_q, out_data_d;
  logic [55:0] skid_data_q, skid_data_d;
  logic        push;
  logic        take;

  // Whole pipeline moves as one while the skid slot is empty; the skid
  // catches the one item that leaves the last stage when the sink stalls,
  // so the ready towards the source comes straight from a flop.
  logic                 adv;
  logic [NumStages-1:0] vld_q;

  split_t split;
  tod_t   tod;
  date_t  date;

  assign adv = ~skid_vld_q;

  ecal_day_split u_split (
    .clk_i   (clk_i),
    .en_i    (adv),
    .secs_i  (s_tdata_i),
    .split_o (split)
  );

  ecal_tod u_tod (
    .clk_i (clk_i),
    .en_i  (adv),
    .sod_i (split.sod),
    .tod_o (tod)
  );

  ecal_civil u_civil (
    .clk_i  (clk_i),
    .en_i   (adv),
    .days_i (split.days),
    .date_o (date)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NumStages-2:0], s_tvalid_i};
    end
  end

  // result word as it leaves the last stage
  logic [55:0] res;
  assign res = {6'b0, tod.second, tod.minute, tod.hour, date.day, date.month, date.year};

  assign push = adv & vld_q[NumStages-1];
  assign take = out_vld_q & m_tready_i;

  always_comb begin
    out_vld_d   = out_vld_q;
    skid_vld_d  = skid_vld_q;
    out_data_d  = out_data_q;
    skid_data_d = skid_data_q;
    if (skid_vld_q) begin
      if (take) begin
        out_data_d = skid_data_q;
        skid_vld_d = 1'b0;
      end
    end else if (push) begin
      if (!out_vld_q || take) begin
        out_data_d = res;
        out_vld_d  = 1'b1;
      end else begin
        skid_data_d = res;
        skid_vld_d  = 1'b1;
      end
    end else if (take) begin
      out_vld_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q  <= 1'b0;
      skid_vld_q <= 1'b0;
    end else begin
      out_vld_q  <= out_vld_d;
      skid_vld_q <= skid_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_data_q  <= out_data_d;
    skid_data_q <= skid_data_d;
  end

  assign s_tready_o = adv;
  assign m_tvalid_o = out_vld_q;
  assign m_tdata_o  = out_data_q;

  // a held skid entry always sits behind a valid output
  a_skid_behind_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    skid_vld_q |-> out_vld_q)
    else $error("skid slot full with empty output register");

  // a full skid only drains through an output transfer
  a_skid_holds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (skid_vld_q && !m_tready_i) |=> (skid_vld_q && !s_tready_o))
    else $error("skid slot lost an item while the sink stalled");

  a_month_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[27:24] >= 4'd1 && m_tdata_o[27:24] <= 4'd12))
    else $error("month out of range");

  a_dtime_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_tvalid_o |-> (m_tdata_o[32:28] >= 5'd1 && m_tdata_o[37:33] <= 5'd23 &&
                    m_tdata_o[43:38] <= 6'd59 && m_tdata_o[49:44] <= 6'd59))
    else $error("day or time of day out of range");

endmodule

/* tb/sv/calendar_result_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// calendar_result_checker: result checker for the epoch to calendar unit
// Watches both stream channels. Each accepted timestamp is converted here
// to the expected date and time of day and queued. Each accepted result is
// compared field by field against the oldest queued date.
// ----------------------------------------------------------------------------
module calendar_result_checker (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_tvalid_i,
  input  logic        s_tready_i,
  input  logic [47:0] s_tdata_i,  // epoch_seconds[47:0]
  input  logic        m_tvalid_i,
  input  logic        m_tready_i,
  input  logic [55:0] m_tdata_i,  // year, month, day, hour, minute, second, pad
  output int          mismatch_count_o,
  output int          dates_outstanding_o
);

  // Same layout as m_tdata, lowest field last
  typedef struct packed {
    logic        [5:0]  pad;
    logic        [5:0]  second;
    logic        [5:0]  minute;
    logic        [4:0]  hour;
    logic        [4:0]  day;
    logic        [3:0]  month;
    logic signed [23:0] year;
  } civil_time_t;

  civil_time_t expected_dates[$];
  civil_time_t want;
  civil_time_t got;
  int          fails;

  // Floor split into days and seconds of day, then 400-year eras counted
  // from 0000-03-01 so the leap day falls at the end of each shifted year.
  function automatic civil_time_t civil_from_epoch(input logic [47:0] raw);
    longint      secs;
    longint      days;
    longint      sod;
    longint      shifted;
    longint      era;
    longint      doe;
    longint      yoe;
    longint      doy;
    longint      mp;
    longint      yr;
    longint      mon;
    civil_time_t c;
    secs = longint'($signed(raw));
    days = secs / 86400;
    sod  = secs % 86400;
    if (sod < 0) begin
      sod  = sod + 86400;
      days = days - 1;
    end
    shifted = days + 719468;
    era     = (shifted >= 0 ? shifted : shifted - 146096) / 146097;
    doe     = shifted - era * 146097;
    yoe     = (doe - doe / 1460 + doe / 36524 - doe / 146096) / 365;
    yr      = yoe + era * 400;
    doy     = doe - (365 * yoe + yoe / 4 - yoe / 100);
    mp      = (5 * doy + 2) / 153;
    mon     = (mp < 10) ? mp + 3 : mp - 9;
    if (mon <= 2) begin
      yr = yr + 1;
    end
    c        = '0;
    c.year   = yr[23:0];
    c.month  = mon[3:0];
    c.day    = 5'(doy - (153 * mp + 2) / 5 + 1);
    c.hour   = 5'(sod / 3600);
    c.minute = 6'((sod % 3600) / 60);
    c.second = 6'(sod % 60);
    return c;
  endfunction

  task automatic flag_field(input string name, input longint exp_v, input longint act_v);
    if (exp_v != act_v) begin
      $display("%0t mismatch %s: expected %0d actual %0d", $time, name, exp_v, act_v);
      fails++;
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      expected_dates.delete();
      fails               = 0;
      mismatch_count_o    <= 0;
      dates_outstanding_o <= 0;
    end else begin
      // result side first, so a same-edge input can never satisfy it
      if (m_tvalid_i && m_tready_i) begin
        got = civil_time_t'(m_tdata_i);
        if (expected_dates.size() == 0) begin
          $display("%0t unexpected result: expected none actual %h", $time, m_tdata_i);
          fails++;
        end else begin
          want = expected_dates.pop_front();
          flag_field("year", longint'(want.year), longint'(got.year));
          flag_field("month", want.month, got.month);
          flag_field("day_of_month", want.day, got.day);
          flag_field("hour", want.hour, got.hour);
          flag_field("minute", want.minute, got.minute);
          flag_field("second", want.second, got.second);
        end
      end
      if (s_tvalid_i && s_tready_i) begin
        expected_dates.push_back(civil_from_epoch(s_tdata_i));
      end
      mismatch_count_o    <= fails;
      dates_outstanding_o <= expected_dates.size();
    end
  end

endmodule

/* tb/sv/epoch_seconds_to_calendar_unit_tb.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// epoch_seconds_to_calendar_unit_tb: stimulus and verdict for the unit
// Drives directed timestamps (epoch, range ends, leap days, century and
// era edges, day edges either side of zero) and then randomised ones,
// with random gaps and stalls on both channels, a long sink hold-off and
// a full drain mid-run. Checking is done by calendar_result_checker.
// ----------------------------------------------------------------------------
module epoch_seconds_to_calendar_unit_tb;

  logic        clk_i      = 1'b0;
  logic        rst_ni     = 1'b0;
  logic        s_tvalid_i = 1'b0;
  logic        s_tready_o;
  logic [47:0] s_tdata_i  = '0;
  logic        m_tvalid_o;
  logic        m_tready_i = 1'b0;
  logic [55:0] m_tdata_o;

  int mismatch_count;
  int dates_outstanding;

  // Idling controls: quiet means no gaps on that side for the phase
  bit quiet_sender  = 1'b0;
  bit quiet_sink    = 1'b0;
  bit hold_off_req  = 1'b0;

  always #5 clk_i = ~clk_i;

  epoch_seconds_to_calendar_unit u_dut (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .s_tvalid_i (s_tvalid_i),
    .s_tready_o (s_tready_o),
    .s_tdata_i  (s_tdata_i),
    .m_tvalid_o (m_tvalid_o),
    .m_tready_i (m_tready_i),
    .m_tdata_o  (m_tdata_o)
  );

  calendar_result_checker u_checker (
    .clk_i               (clk_i),
    .rst_ni              (rst_ni),
    .s_tvalid_i          (s_tvalid_i),
    .s_tready_i          (s_tready_o),
    .s_tdata_i           (s_tdata_i),
    .m_tvalid_i          (m_tvalid_o),
    .m_tready_i          (m_tready_i),
    .m_tdata_i           (m_tdata_o),
    .mismatch_count_o    (mismatch_count),
    .dates_outstanding_o (dates_outstanding)
  );

  // Offer one timestamp; returns at the edge of its transfer. Valid is only
  // dropped when a gap follows, so back-to-back items keep it high.
  task automatic offer_epoch(input logic [47:0] secs);
    int gap;
    gap = quiet_sender ? 0 : $urandom_range(0, 16);
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= secs;
    do @(posedge clk_i); while (!s_tready_o);
  endtask

  // Checker count is registered, hence the leading edge
  task automatic wait_all_dates_back();
    do @(posedge clk_i); while (dates_outstanding != 0);
  endtask

  // Random timestamp: whole range, near the epoch, around midnights, or
  // around the starts of eras and centuries (leap-day handling).
  function automatic logic [47:0] random_epoch();
    longint secs;
    longint days;
    case ($urandom_range(0, 3))
      0: secs = {$urandom, $urandom};
      1: secs = longint'(int'($urandom));
      2: begin
        days = longint'($urandom_range(0, 2000000)) - 1000000;
        secs = days * 86400 + longint'($urandom_range(0, 4)) - 2;
      end
      default: begin
        days = (longint'($urandom_range(0, 40)) - 20) * 146097
               + longint'($urandom_range(0, 3)) * 36524 - 719468;
        secs = days * 86400 + longint'($urandom_range(0, 172800)) - 86400;
      end
    endcase
    return secs[47:0];
  endfunction

  // Sink: random stalls per result, plus a long hold-off on request
  initial begin
    @(posedge rst_ni);
    forever begin
      int stall;
      if (hold_off_req) begin
        hold_off_req = 1'b0;
        stall        = 300;
      end else begin
        stall = quiet_sink ? 0 : $urandom_range(0, 16);
      end
      if (stall > 0) begin
        m_tready_i <= 1'b0;
        repeat (stall) @(posedge clk_i);
      end
      m_tready_i <= 1'b1;
      do @(posedge clk_i); while (!m_tvalid_o);
    end
  end

  initial begin
    longint directed_secs[$];
    directed_secs = '{
      0, -1, 1,                                  // epoch and its neighbours
      64'sd140737488355327, -64'sd140737488355328, // range ends
      86399, 86400, -86400, -86401,              // midnight either side of zero
      68169600, 951782400, 951868800,            // leap days 1972 and 2000
      64'sd4107456000, 64'sd4107542400,          // 2100 is not a leap year
      -64'sd2203891200, 946684799,               // 1900-03-01, end of 1999
      64'sd253402300799,                         // last second of 9999
      -64'sd62167219200, -64'sd62167219201,      // start of year 0, end of year -1
      -64'sd62162035200, -64'sd62162035201,      // era origin, 0000-03-01
      64'sd2147483647, -64'sd2147483648,         // 32-bit edges
      48'h5555_5555_5555, 48'hAAAA_AAAA_AAAA
    };

    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (directed_secs[i]) begin
      offer_epoch(directed_secs[i][47:0]);
    end

    repeat (400) begin
      offer_epoch(random_epoch());
    end

    // Sender pause until the pipeline has emptied completely
    s_tvalid_i <= 1'b0;
    wait_all_dates_back();

    // Long sink hold-off with the sender flat out, to fill the pipeline
    hold_off_req = 1'b1;
    quiet_sender = 1'b1;
    repeat (60) begin
      offer_epoch(random_epoch());
    end
    quiet_sender = 1'b0;

    for (int n = 0; n < 620; n++) begin
      if (n % 50 == 0) begin
        quiet_sender = ($urandom_range(0, 3) == 0);
        quiet_sink   = ($urandom_range(0, 3) == 0);
      end
      offer_epoch(random_epoch());
    end
    s_tvalid_i <= 1'b0;

    wait_all_dates_back();
    repeat (20) @(posedge clk_i);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // Hang guard, well beyond the slowest legal run
  initial begin
    #5ms;
    $display("status: fail");
    $finish;
  end

endmodule
